@@ hdl/adclb_pkg.sv @@
// Shared types and constants for the resistor-ladder keypad sampler.
package adclb_pkg;

  // Field widths
  localparam int unsigned SampleWidth = 10;
  localparam int unsigned RegWidth    = 8;
  localparam int unsigned NumButtons  = 3;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned RegIdxWidth = 3;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [RegWidth-1:0]    reg_t;
  typedef logic [RegIdxWidth-1:0] reg_index_t;
  typedef logic [NumButtons-1:0]  button_vec_t;

  // Configuration register indexes
  localparam reg_index_t RegPrescale    = 3'd0;
  localparam reg_index_t RegBlink       = 3'd1;
  localparam reg_index_t RegFirstUpper  = 3'd2;
  localparam reg_index_t RegSecondLower = 3'd3;
  localparam reg_index_t RegSecondUpper = 3'd4;
  localparam reg_index_t RegThirdLower  = 3'd5;
  localparam reg_index_t RegThirdUpper  = 3'd6;
  localparam reg_index_t RegPattern     = 3'd7;

  // Configuration reset values
  localparam reg_t PrescaleReset    = 8'd10;
  localparam reg_t BlinkReset       = 8'd20;
  localparam reg_t FirstUpperReset  = 8'd10;
  localparam reg_t SecondLowerReset = 8'd100;
  localparam reg_t SecondUpperReset = 8'd150;
  localparam reg_t ThirdLowerReset  = 8'd160;
  localparam reg_t ThirdUpperReset  = 8'd200;
  localparam reg_t PatternReset     = 8'b1111_0000;

  // Each button history starts as one.
  localparam reg_t HistoryReset = 8'd1;

  // One result word
  typedef struct packed {
    logic        led_level;
    button_vec_t trigger;
    logic        sample_taken;
  } result_t;

endpackage

@@ hdl/adc_ladder_button_edge_detector.sv @@
// Keypad sampler top level: prescaler, blink LED, window decode and press detection.
//
// Each input word is one timer tick carrying a 10-bit ladder sample; every tick
// yields exactly one result word. Every prescale_count-th tick is a sample tick:
// the blink counter steps (toggling the LED when it reaches blink_count), the
// upper 8 bits of the sample are decoded against three windows into active-low
// button levels, each trigger is set when that button's history (before the
// shift) equals trigger_pattern, and the level is then shifted into the history.
// Triggers hold between sample ticks. A prescale or blink count of zero gives a
// period of 256. The block takes one word per clock cycle while in_stall is low;
// all per-tick work is one registered stage of counters and comparators, and a
// two-entry output buffer (result register plus skid register) keeps input
// acceptance going while a result waits. Configuration writes are taken at any
// clock edge where cfg_write is high; unknown indexes are ignored.
module adc_ladder_button_edge_detector (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port
  input  logic                   cfg_write,
  input  adclb_pkg::reg_index_t  cfg_index,
  input  adclb_pkg::reg_t        cfg_data,
  // Input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  adclb_pkg::sample_t     adc_sample,
  // Output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   led_level,
  output logic                   first_trigger,
  output logic                   second_trigger,
  output logic                   third_trigger,
  output logic                   sample_taken
);

  import adclb_pkg::*;

  // Configuration registers
  reg_t prescale_count;
  reg_t blink_count;
  reg_t first_upper_limit;
  reg_t second_lower_limit;
  reg_t second_upper_limit;
  reg_t third_lower_limit;
  reg_t third_upper_limit;
  reg_t trigger_pattern;

  // Block state
  reg_t        tick_counter;
  reg_t        blink_counter;
  logic        led;
  reg_t        history [NumButtons];
  button_vec_t trigger;

  reg_t        tick_counter_next;
  reg_t        blink_counter_next;
  logic        led_next;
  reg_t        history_next [NumButtons];
  button_vec_t trigger_next;

  // Output buffer
  result_t result;
  result_t skid;
  logic    skid_valid;

  logic        accept;
  logic        drain;
  logic        sample_tick;
  logic        blink_hit;
  reg_t        tick_inc;
  reg_t        blink_inc;
  reg_t        reduced;
  button_vec_t level;
  result_t     result_next;

  assign accept = in_valid && !in_stall;
  assign drain  = out_valid && !out_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count     <= PrescaleReset;
      blink_count        <= BlinkReset;
      first_upper_limit  <= FirstUpperReset;
      second_lower_limit <= SecondLowerReset;
      second_upper_limit <= SecondUpperReset;
      third_lower_limit  <= ThirdLowerReset;
      third_upper_limit  <= ThirdUpperReset;
      trigger_pattern    <= PatternReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegPrescale:    prescale_count     <= cfg_data;
        RegBlink:       blink_count        <= cfg_data;
        RegFirstUpper:  first_upper_limit  <= cfg_data;
        RegSecondLower: second_lower_limit <= cfg_data;
        RegSecondUpper: second_upper_limit <= cfg_data;
        RegThirdLower:  third_lower_limit  <= cfg_data;
        RegThirdUpper:  third_upper_limit  <= cfg_data;
        RegPattern:     trigger_pattern    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Prescaler and blink counter.
  always_comb begin
    tick_inc           = tick_counter + 8'd1;
    sample_tick        = (tick_inc == prescale_count);
    tick_counter_next  = sample_tick ? '0 : tick_inc;
    blink_inc          = blink_counter + 8'd1;
    blink_hit          = sample_tick && (blink_inc == blink_count);
    blink_counter_next = sample_tick ? (blink_hit ? '0 : blink_inc) : blink_counter;
    led_next           = led ^ blink_hit;
  end

  // Window decode; a zero level means the button is pressed.
  always_comb begin
    reduced  = adc_sample[SampleWidth-1 -: RegWidth];
    level[0] = !(reduced < first_upper_limit);
    level[1] = !((reduced > second_lower_limit) && (reduced < second_upper_limit));
    level[2] = !((reduced > third_lower_limit) && (reduced < third_upper_limit));
  end

  // Press detection compares the history before the shift.
  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      if (sample_tick) begin
        trigger_next[i] = (history[i] == trigger_pattern);
        history_next[i] = {history[i][RegWidth-2:0], level[i]};
      end else begin
        trigger_next[i] = trigger[i];
        history_next[i] = history[i];
      end
    end
    result_next.led_level    = led_next;
    result_next.trigger      = trigger_next;
    result_next.sample_taken = sample_tick;
  end

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      blink_counter <= '0;
      led           <= 1'b1;
      trigger       <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        history[i] <= HistoryReset;
      end
    end else if (accept) begin
      tick_counter  <= tick_counter_next;
      blink_counter <= blink_counter_next;
      led           <= led_next;
      trigger       <= trigger_next;
      for (int i = 0; i < NumButtons; i++) begin
        history[i] <= history_next[i];
      end
    end
  end

  // Output buffer control: the skid register catches a word while the result is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept && out_valid && !drain) begin
        skid_valid <= 1'b1;
      end else if (drain) begin
        skid_valid <= 1'b0;
      end
      if (drain) begin
        out_valid <= skid_valid || accept;
      end else if (accept) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (accept && out_valid && !drain) begin
      skid <= result_next;
    end
    if (drain && skid_valid) begin
      result <= skid;
    end else if (accept && (!out_valid || drain)) begin
      result <= result_next;
    end
  end

  assign in_stall       = skid_valid;
  assign led_level      = result.led_level;
  assign first_trigger  = result.trigger[0];
  assign second_trigger = result.trigger[1];
  assign third_trigger  = result.trigger[2];
  assign sample_taken   = result.sample_taken;

endmodule
